// File: sv/hst_pkg.sv
// Shared types and constants for the heater safety thermostat.
package hst_pkg;

  // Default watchdog reload, in seconds ticks.
  localparam int WATCHDOG_SECONDS_DEF = 5;

  // Field widths.
  localparam int MODE_W = 3;
  localparam int TEMP_W = 16;
  localparam int HYST_W = 15;
  localparam int FLAG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRIP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MAN_ON = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MAN_OFF = 3'd5;

  // Fault flag masks.
  localparam logic [FLAG_W-1:0] FLAG_SENSOR = 4'b0001;
  localparam logic [FLAG_W-1:0] FLAG_MAXTEMP = 4'b0010;
  localparam logic [FLAG_W-1:0] FLAG_WATCHDOG = 4'b0100;
  localparam logic [FLAG_W-1:0] FLAG_OTP = 4'b1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_ON = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd3;

  // Reset value of the over-temperature limit (350 degrees C).
  localparam logic signed [TEMP_W-1:0] OVER_TEMP_LIMIT_RST = 16'sd5600;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temp;
    logic [HYST_W-1:0]        hysteresis;
    logic                     regulation_on;
    logic signed [TEMP_W-1:0] over_temp_limit;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [TEMP_W-1:0] temperature;
    logic                     sensor_fault;
    logic                     otp_pin;
  } item_t;

  typedef struct packed {
    logic              heater_on;
    logic [FLAG_W-1:0] fault_flags;
    logic              temp_reached;
  } result_t;

endpackage

// File: sv/hst_cfg_regs.sv
// Configuration register bank of the heater safety thermostat.
module hst_cfg_regs
  import hst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Register writes, decoded by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp <= '0;
      cfg.hysteresis <= '0;
      cfg.regulation_on <= 1'b0;
      cfg.over_temp_limit <= OVER_TEMP_LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TARGET: cfg.target_temp <= wr_data;
        CFG_HYST:   cfg.hysteresis <= wr_data[HYST_W-1:0];
        CFG_REG_ON: cfg.regulation_on <= wr_data[0];
        CFG_LIMIT:  cfg.over_temp_limit <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/hst_core.sv
// Fault latch, watchdog and heater state with the per-request update logic.
module hst_core
  import hst_pkg::*;
#(
  parameter int WATCHDOG_SECONDS = WATCHDOG_SECONDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int WD_W = $clog2(WATCHDOG_SECONDS + 1);
  localparam logic [WD_W-1:0] WD_RELOAD = WD_W'(WATCHDOG_SECONDS);

  logic [FLAG_W-1:0]        fault_latch;
  logic [WD_W-1:0]          watchdog_count;
  logic                     heater_drive;

  logic [FLAG_W-1:0]        fault_latch_next;
  logic [WD_W-1:0]          watchdog_count_next;
  logic                     heater_drive_next;
  logic [FLAG_W-1:0]        check_flags;
  logic signed [TEMP_W:0]   band_low;
  logic signed [TEMP_W:0]   temp_ext;
  logic                     over_limit;
  logic                     at_target;
  logic                     below_band;
  logic                     reached;

  // Band floor is one bit wider so target minus hysteresis never wraps.
  assign band_low = $signed({cfg.target_temp[TEMP_W-1], cfg.target_temp})
                  - $signed({2'b00, cfg.hysteresis});
  assign temp_ext = $signed({item.temperature[TEMP_W-1], item.temperature});
  assign over_limit = item.temperature >= cfg.over_temp_limit;
  assign at_target = item.temperature >= cfg.target_temp;
  assign below_band = temp_ext < band_low;
  assign reached = !item.sensor_fault && !below_band;

  // Flags that a sample check adds; a sensor fault masks the other checks.
  always_comb begin
    check_flags = '0;
    if (item.sensor_fault) begin
      check_flags = FLAG_SENSOR;
    end else begin
      if (over_limit) check_flags = check_flags | FLAG_MAXTEMP;
      if (item.otp_pin) check_flags = check_flags | FLAG_OTP;
    end
  end

  // Next state and result for the current request.
  always_comb begin
    fault_latch_next = fault_latch;
    watchdog_count_next = watchdog_count;
    heater_drive_next = heater_drive;
    result.temp_reached = 1'b0;
    case (item.mode)
      MODE_SAMPLE: begin
        fault_latch_next = fault_latch | check_flags;
        if (check_flags != '0) begin
          heater_drive_next = 1'b0;
        end else if (fault_latch == '0) begin
          watchdog_count_next = WD_RELOAD;
          if (cfg.regulation_on) begin
            if (at_target) heater_drive_next = 1'b0;
            else if (below_band) heater_drive_next = 1'b1;
          end
        end
        result.temp_reached = reached;
      end
      MODE_TICK: begin
        if (watchdog_count != '0) begin
          watchdog_count_next = watchdog_count - 1'b1;
        end else begin
          fault_latch_next = fault_latch | FLAG_WATCHDOG;
          heater_drive_next = 1'b0;
        end
      end
      MODE_CLEAR: begin
        fault_latch_next = check_flags;
        if (check_flags != '0) heater_drive_next = 1'b0;
        result.temp_reached = reached;
      end
      MODE_TRIP: begin
        fault_latch_next = fault_latch | FLAG_OTP;
        heater_drive_next = 1'b0;
      end
      MODE_MAN_ON: begin
        heater_drive_next = (fault_latch == '0);
      end
      MODE_MAN_OFF: begin
        heater_drive_next = 1'b0;
      end
      default: begin
      end
    endcase
    result.heater_on = heater_drive_next;
    result.fault_flags = fault_latch_next;
  end

  // State registers, updated once per request handed to the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_latch <= '0;
      watchdog_count <= WD_RELOAD;
      heater_drive <= 1'b0;
    end else if (advance) begin
      fault_latch <= fault_latch_next;
      watchdog_count <= watchdog_count_next;
      heater_drive <= heater_drive_next;
    end
  end

  // The heater is never driven while any fault is latched.
  a_heater_off_on_fault: assert property (@(posedge clk) disable iff (rst)
    !(heater_drive && fault_latch != '0))
    else $error("heater driven with a fault latched");

  // Faults stay latched unless a clear request was processed.
  a_flags_sticky: assert property (@(posedge clk) disable iff (rst)
    (advance && item.mode != MODE_CLEAR) |=>
      ((fault_latch & $past(fault_latch)) == $past(fault_latch)))
    else $error("fault flag dropped without a clear request");

  // The watchdog never counts above its reload value.
  a_wd_range: assert property (@(posedge clk) disable iff (rst)
    watchdog_count <= WD_RELOAD)
    else $error("watchdog count above reload value");

endmodule

// File: sv/heater_safety_thermostat_top.sv
// Top level of the heater safety thermostat: request and result stages.
// One request is taken every clock cycle unless result_stall holds the
// pipeline. A request sits in the input register while the fault, watchdog
// and thermostat logic works on it, and its result is loaded into the
// result register once the result stage is free. A result held by
// result_stall holds the request behind it in the input register, and that
// in turn stalls the request channel. Configuration writes are always ready
// and take effect on the next request.
module heater_safety_thermostat_top
  import hst_pkg::*;
#(
  parameter int WATCHDOG_SECONDS = WATCHDOG_SECONDS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Request channel
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic                     sensor_fault,
  input  logic                     otp_pin,
  // Result channel
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     heater_on,
  output logic [FLAG_W-1:0]        fault_flags,
  output logic                     temp_reached,
  // Configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t core_result;
  result_t result;
  logic    out_free;
  logic    advance;
  logic    take;

  assign cfg_ready = 1'b1;

  hst_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline flow control.
  assign out_free = !result_valid || !result_stall;
  assign advance = item_valid && out_free;
  assign sample_stall = item_valid && !out_free;
  assign take = sample_valid && !sample_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.mode <= mode;
      item.temperature <= temperature;
      item.sensor_fault <= sensor_fault;
      item.otp_pin <= otp_pin;
    end
  end

  hst_core #(
    .WATCHDOG_SECONDS (WATCHDOG_SECONDS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  assign heater_on = result.heater_on;
  assign fault_flags = result.fault_flags;
  assign temp_reached = result.temp_reached;

  // A request held back by a full result stage is not lost.
  a_held_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !out_free) |=> item_valid)
    else $error("held request dropped from input register");

  // Every processed request lands in the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("processed request produced no result");

endmodule
